/* sv/mmh2_pkg.sv */
// ----------------------------------------------------------------------------
// mmh2_pkg: shared types and constants for the bucket hash block
// Field widths, mix constants, configuration indexes and the hash sequencer
// states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package mmh2_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned NB_W   = 3;
  localparam int unsigned KLEN_W = 16;

  localparam logic [WORD_W-1:0] MIX_MUL     = 32'h5bd1e995;
  localparam int unsigned       MIX_SHIFT   = 24;
  localparam int unsigned       FIN_SHIFT_A = 13;
  localparam int unsigned       FIN_SHIFT_B = 15;

  localparam logic [NB_W-1:0]   NB_FULL     = 3'd4;

  localparam logic CFG_SEED       = 1'b0;
  localparam logic CFG_TABLE_SIZE = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] key_word;
    logic [NB_W-1:0]   nbytes;
    logic [KLEN_W-1:0] key_len;
    logic              closes;
  } word_item_t;

  typedef enum logic [2:0] {
    MX_IDLE,
    MX_K1,
    MX_K2,
    MX_H,
    MX_TAIL,
    MX_FIN,
    MX_SEND
  } mix_state_t;

endpackage
`default_nettype wire

/* sv/murmur2_bucket_hash.sv */
// ----------------------------------------------------------------------------
// murmur2_bucket_hash: streaming 32-bit MurmurHash2 with bucket reduction
// Hashes keys delivered as little-endian words; when a key closes, returns the
// raw hash and the hash modulo the table size, or the raw hash again if 0.
//
//   channel  direction  payload
//   s_*      in         tdata: key_word, bytes_valid, key_len; tlast: last
//   m_*      out        tdata: bucket_index, raw_hash
//   cfg_*    in         index 0 seed, index 1 table_size
//
// A full word that does not close the key enters the sequencer and then takes
// three multiplies on the shared multiplier. A closing item adds a finalize
// multiply and a hand-off, then the bit-serial remainder unit, which overlaps
// with the next key's words.
// Reset clears control state and sets seed 0, table_size 1024.
// The two-entry input queue and the output register let each side stall alone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module murmur2_bucket_hash
  import mmh2_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // key_word[31:0], bytes_valid[34:32], key_len[50:35]
  input  wire logic        s_tlast,   // last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // bucket_index[31:0], raw_hash[63:32]
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [WORD_W-1:0] seed;
  logic [WORD_W-1:0] table_size;
  logic              q_valid;
  logic              q_ready;
  word_item_t        q_item;
  logic              fin_valid;
  logic              fin_ready;
  logic [WORD_W-1:0] fin_hash;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed       <= '0;
      table_size <= 32'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEED:       seed       <= cfg_data;
        CFG_TABLE_SIZE: table_size <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mmh2_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_ready  (q_ready)
  );

  mmh2_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready),
    .seed      (seed),
    .fin_valid (fin_valid),
    .fin_hash  (fin_hash),
    .fin_ready (fin_ready)
  );

  mmh2_mod u_mod (
    .clk        (clk),
    .rst        (rst),
    .fin_valid  (fin_valid),
    .fin_hash   (fin_hash),
    .fin_ready  (fin_ready),
    .table_size (table_size),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule
`default_nettype wire

/* sv/mmh2_front.sv */
// ----------------------------------------------------------------------------
// mmh2_front: input acceptance and classification
// Clamps the byte count, flags key-closing items and buffers them in a
// two-entry queue toward the hash sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mmh2_front
  import mmh2_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [55:0]      s_tdata,  // key_word, bytes_valid, key_len
  input  wire logic             s_tlast,  // last
  output logic                  q_valid,
  output word_item_t            q_item,
  input  wire logic             q_ready
);

  word_item_t       q_mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic [NB_W-1:0]  nb_raw;
  word_item_t       in_item;
  logic             push;
  logic             pop;

  assign nb_raw   = s_tdata[34:32];
  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = q_mem[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    in_item.key_word = s_tdata[31:0];
    in_item.nbytes   = (nb_raw > NB_FULL) ? NB_FULL : nb_raw;
    in_item.key_len  = s_tdata[50:35];
    in_item.closes   = (in_item.nbytes != NB_FULL) || s_tlast;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/mmh2_mix.sv */
// ----------------------------------------------------------------------------
// mmh2_mix: hash sequencer
// Runs the word mix, tail fold and finalization through one shared multiplier
// and hands the finished hash onward; one multiply per cycle unless waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mmh2_mix
  import mmh2_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire word_item_t        q_item,
  output logic                   q_ready,
  input  wire logic [WORD_W-1:0] seed,
  output logic                   fin_valid,
  output logic [WORD_W-1:0]      fin_hash,
  input  wire logic              fin_ready
);

  mix_state_t         state;
  mix_state_t         state_next;
  logic [WORD_W-1:0]  h;
  logic [WORD_W-1:0]  k;
  logic [WORD_W-1:0]  acc;
  logic [NB_W-1:0]    nbytes;
  logic               closes;
  logic               in_key;
  logic [WORD_W-1:0]  mul_a;
  logic [WORD_W-1:0]  prod;
  logic [WORD_W-1:0]  tail_mask;
  logic [WORD_W-1:0]  h_start;

  assign prod      = mul_a * MIX_MUL;
  assign fin_hash  = h;
  assign h_start   = in_key ? acc : (seed ^ WORD_W'(q_item.key_len));

  always_comb begin
    case (nbytes)
      3'd1:    tail_mask = 32'h000000ff;
      3'd2:    tail_mask = 32'h0000ffff;
      3'd3:    tail_mask = 32'h00ffffff;
      default: tail_mask = 32'h00000000;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      MX_IDLE: begin
        if (q_valid) begin
          if (q_item.nbytes == NB_FULL) begin
            state_next = MX_K1;
          end else if (q_item.nbytes == 3'd0) begin
            state_next = MX_FIN;
          end else begin
            state_next = MX_TAIL;
          end
        end
      end
      MX_K1:   state_next = MX_K2;
      MX_K2:   state_next = MX_H;
      MX_H:    state_next = closes ? MX_FIN : MX_IDLE;
      MX_TAIL: state_next = MX_FIN;
      MX_FIN:  state_next = MX_SEND;
      MX_SEND: state_next = fin_ready ? MX_IDLE : MX_SEND;
      default: state_next = MX_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = (state == MX_IDLE);
    fin_valid = (state == MX_SEND);
    case (state)
      MX_K1:   mul_a = k;
      MX_K2:   mul_a = k ^ (k >> MIX_SHIFT);
      MX_H:    mul_a = h;
      MX_TAIL: mul_a = h ^ (k & tail_mask);
      MX_FIN:  mul_a = h ^ (h >> FIN_SHIFT_A);
      default: mul_a = h;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= MX_IDLE;
      in_key <= 1'b0;
      acc    <= '0;
    end else begin
      state <= state_next;
      case (state)
        MX_H: begin
          if (!closes) begin
            acc    <= prod ^ k;
            in_key <= 1'b1;
          end
        end
        MX_SEND: begin
          if (fin_ready) begin
            acc    <= '0;
            in_key <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MX_IDLE: begin
        if (q_valid) begin
          h      <= h_start;
          k      <= q_item.key_word;
          nbytes <= q_item.nbytes;
          closes <= q_item.closes;
        end
      end
      MX_K1:   k <= prod;
      MX_K2:   k <= prod;
      MX_H:    h <= prod ^ k;
      MX_TAIL: h <= prod;
      MX_FIN:  h <= prod ^ (prod >> FIN_SHIFT_B);
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/mmh2_mod.sv */
// ----------------------------------------------------------------------------
// mmh2_mod: bucket reduction and output register
// Reduces the finished hash modulo a nonzero table size, one remainder bit per
// cycle, and holds the result item for the downstream side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module mmh2_mod
  import mmh2_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fin_valid,
  input  wire logic [WORD_W-1:0] fin_hash,
  output logic                   fin_ready,
  input  wire logic [WORD_W-1:0] table_size,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [63:0]            m_tdata
);

  logic               busy;
  logic               pend;
  logic [4:0]         cnt;
  logic [WORD_W-1:0]  dvd;
  logic [WORD_W-1:0]  dvs;
  logic [WORD_W-1:0]  rem;
  logic [WORD_W-1:0]  hash_r;
  logic [WORD_W:0]    shifted;
  logic [WORD_W:0]    diff;
  logic               ge;
  logic               take;

  assign fin_ready = !busy && !pend;
  assign take      = fin_valid && fin_ready;
  assign shifted   = {rem, dvd[WORD_W-1]};
  assign ge        = (shifted >= {1'b0, dvs});
  assign diff      = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        busy <= (table_size != '0);
        pend <= (table_size == '0);
      end else if (busy && cnt == 5'd0) begin
        busy <= 1'b0;
        pend <= 1'b1;
      end else if (pend && (!m_tvalid || m_tready)) begin
        pend <= 1'b0;
      end
      if (pend && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hash_r <= fin_hash;
      dvd    <= fin_hash;
      dvs    <= table_size;
      cnt    <= 5'd31;
      rem    <= (table_size == '0) ? fin_hash : '0;
    end else if (busy) begin
      rem <= ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
      dvd <= {dvd[WORD_W-2:0], 1'b0};
      cnt <= cnt - 5'd1;
    end
    if (pend && (!m_tvalid || m_tready)) begin
      m_tdata <= {hash_r, rem};
    end
  end

endmodule
`default_nettype wire

/* sim/mmh2_bucket_checker.sv */
// ----------------------------------------------------------------------------
// mmh2_bucket_checker: hash prediction and result checking
// Watches the configuration port and both streams of the bucket hash block.
// Each accepted input item runs through a software MurmurHash2 word mix.
// Each closed key queues its raw hash and bucket index. Results leaving the
// block are compared in order against that queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mmh2_bucket_checker
  import mmh2_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,   // key_word[31:0], bytes_valid[34:32], key_len[50:35]
  input  logic        s_tlast,   // last
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,   // bucket_index[31:0], raw_hash[63:32]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [31:0] bucket_index;
    logic [31:0] raw_hash;
  } bucket_hash_t;

  bucket_hash_t      hash_q[$];
  logic [31:0]       seed_r;
  logic [31:0]       tsize_r;
  logic [31:0]       acc;
  logic              open_key;

  task automatic hash_word(input logic [31:0] w, input logic [2:0] nb_in,
                           input logic [15:0] klen, input logic lst);
    logic [31:0]  h;
    logic [31:0]  k;
    logic [2:0]   nb;
    bucket_hash_t r;
    nb = (nb_in > NB_FULL) ? NB_FULL : nb_in;
    h = open_key ? acc : (seed_r ^ {16'd0, klen});
    open_key = 1'b1;
    if (nb == NB_FULL) begin
      k = w * MIX_MUL;
      k = k ^ (k >> MIX_SHIFT);
      k = k * MIX_MUL;
      h = h * MIX_MUL;
      h = h ^ k;
    end else if (nb != 3'd0) begin
      if (nb == 3'd3) h = h ^ (w & 32'h00FF_0000);
      if (nb >= 3'd2) h = h ^ (w & 32'h0000_FF00);
      h = h ^ (w & 32'h0000_00FF);
      h = h * MIX_MUL;
    end
    if (nb == NB_FULL && !lst) begin
      acc = h;
    end else begin
      h = h ^ (h >> FIN_SHIFT_A);
      h = h * MIX_MUL;
      h = h ^ (h >> FIN_SHIFT_B);
      r.raw_hash     = h;
      r.bucket_index = (tsize_r != 32'd0) ? (h % tsize_r) : h;
      hash_q.push_back(r);
      acc      = 32'd0;
      open_key = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    bucket_hash_t want;
    if (rst) begin
      seed_r   = 32'd0;
      tsize_r  = 32'd1024;
      acc      = 32'd0;
      open_key = 1'b0;
      hash_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SEED) seed_r = cfg_data;
        else tsize_r = cfg_data;
      end
      if (s_tvalid && s_tready)
        hash_word(s_tdata[31:0], s_tdata[34:32], s_tdata[50:35], s_tlast);
      if (m_tvalid && m_tready) begin
        if (hash_q.size() == 0) begin
          $error("unexpected result: bucket_index %h raw_hash %h",
                 m_tdata[31:0], m_tdata[63:32]);
          errors++;
        end else begin
          want = hash_q.pop_front();
          if (m_tdata[31:0] !== want.bucket_index) begin
            $error("bucket_index: expected %h, got %h", want.bucket_index, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[63:32] !== want.raw_hash) begin
            $error("raw_hash: expected %h, got %h", want.raw_hash, m_tdata[63:32]);
            errors++;
          end
        end
      end
    end
    pending = hash_q.size();
  end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for murmur2_bucket_hash
// Drives directed keys covering tail lengths, out-of-range byte counts,
// mismatched key lengths and register extremes, then random keys over
// several seed and table size settings. Both streams idle at random; the
// result side also holds off once for a long stretch. Checking is done in
// mmh2_bucket_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import mmh2_pkg::*;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata   = '0;   // key_word[31:0], bytes_valid[34:32], key_len[50:35]
  logic        s_tlast   = 1'b0; // last
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [63:0] m_tdata;          // bucket_index[31:0], raw_hash[63:32]
  logic        cfg_we    = 1'b0;
  logic        cfg_index = CFG_SEED;
  logic [31:0] cfg_data  = '0;
  logic        hold_req  = 1'b0;

  int errors;
  int pending;
  int burst_left = 0;
  int items_sent = 0;
  int rx_cycle   = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  murmur2_bucket_hash i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  mmh2_bucket_checker i_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending)
  );

  // result side: rotate through always ready, random and sparse ready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 400;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      rx_cycle++;
      case ((rx_cycle / 200) % 3)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(0, 1) == 0);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic push_item(input logic [31:0] w, input logic [2:0] nb,
                           input logic [15:0] klen, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, klen, nb, w};
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // well-formed key: full words, then a tail or a full word marked last
  task automatic push_key(input int unsigned len, input logic [15:0] klen);
    int unsigned left;
    logic [15:0] kl;
    logic [2:0]  nb;
    left = len;
    kl   = klen;
    while (left != 0) begin
      if (left > 4) begin
        push_item($urandom, NB_FULL, kl, 1'b0);
        left = left - 4;
      end else begin
        nb = 3'(left);
        push_item($urandom, nb, kl, (left == 4) ? 1'b1 : 1'($urandom_range(0, 1)));
        left = 0;
      end
      kl = 16'($urandom);
    end
  endtask

  // write a register once the block has drained
  task automatic set_reg(input logic idx, input logic [31:0] val);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int unsigned len;
    int          n;
    logic [31:0] tsize;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers at reset values: single-byte to full-word keys, top bits set
    push_item(32'hFFFF_FF61, 3'd1, 16'd1, 1'b1);
    push_item(32'h1234_5678, 3'd2, 16'd2, 1'b0);
    push_item(32'hFFFF_FFFF, 3'd3, 16'd3, 1'b1);
    push_item(32'hFFFF_FFFF, NB_FULL, 16'd4, 1'b1);
    // multiword key, stated length wrong, length field changes after first word
    push_item(32'h0000_0000, NB_FULL, 16'hFFFF, 1'b0);
    push_item(32'hFFFF_FFFF, NB_FULL, 16'h0000, 1'b0);
    push_item(32'h8080_8080, 3'd2, 16'hFFFF, 1'b1);
    // zero bytes on a fresh key, then byte counts above four
    push_item(32'hDEAD_BEEF, 3'd0, 16'd0, 1'b0);
    push_item(32'hA5A5_A5A5, 3'd5, 16'h8000, 1'b0);
    push_item(32'h5A5A_5A5A, 3'd6, 16'd7, 1'b0);
    push_item(32'h0102_0304, 3'd7, 16'd9, 1'b1);
    // zero bytes closing a key in progress
    push_item(32'hCAFE_F00D, NB_FULL, 16'd8, 1'b0);
    push_item(32'hFFFF_FFFF, 3'd0, 16'd8, 1'b1);

    set_reg(CFG_SEED, 32'hFFFF_FFFF);
    set_reg(CFG_TABLE_SIZE, 32'hFFFF_FFFF);
    push_item(32'h0000_0000, NB_FULL, 16'd4, 1'b1);
    push_item(32'hFFFF_FFFF, 3'd3, 16'd3, 1'b0);
    push_item(32'h0000_0000, 3'd1, 16'd1, 1'b1);

    set_reg(CFG_TABLE_SIZE, 32'd0);
    push_item($urandom, NB_FULL, 16'd4, 1'b1);
    push_item(32'hFFFF_FFFF, NB_FULL, 16'hFFFF, 1'b1);

    set_reg(CFG_TABLE_SIZE, 32'd1);
    set_reg(CFG_SEED, 32'd0);
    push_item($urandom, 3'd2, 16'd2, 1'b1);
    push_item($urandom, NB_FULL, 16'd5, 1'b1);

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       tsize = $urandom;
        1:       tsize = 32'd1;
        2:       tsize = 32'hFFFF_FFFF;
        3:       tsize = 32'd1 << $urandom_range(0, 31);
        4:       tsize = 32'd0;
        default: tsize = $urandom_range(1, 1000);
      endcase
      set_reg(CFG_SEED, (p == 1) ? 32'd0 : (p == 2) ? 32'hFFFF_FFFF : $urandom);
      set_reg(CFG_TABLE_SIZE, tsize);
      n = items_sent + 180;
      while (items_sent < n) begin
        if (p == 0 && items_sent > n - 100) hold_req <= 1'b1;
        if ($urandom_range(0, 99) < 15) begin
          // broken sequence: random byte counts, flags and lengths
          repeat ($urandom_range(1, 6))
            push_item($urandom, 3'($urandom_range(0, 7)), 16'($urandom),
                      1'($urandom_range(0, 1)));
        end else begin
          case ($urandom_range(0, 19))
            0:       len = $urandom_range(65, 255);
            1, 2, 3,
            4, 5:    len = $urandom_range(17, 64);
            default: len = $urandom_range(1, 16);
          endcase
          push_key(len, ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(len));
        end
      end
      // close any open key before the registers change
      push_item($urandom, 3'($urandom_range(0, 3)), 16'($urandom), 1'($urandom_range(0, 1)));
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* murmur2_bucket_hash.f */
sv/mmh2_pkg.sv
sv/mmh2_front.sv
sv/mmh2_mix.sv
sv/mmh2_mod.sv
sv/murmur2_bucket_hash.sv
sim/mmh2_bucket_checker.sv
sim/tb_top.sv
